@@ rtl/rcpd_pkg.sv @@
// Shared constants and types for the multichannel pulse decoder.
package rcpd_pkg;

   // Field widths
   localparam int COUNT_W  = 7;
   localparam int GAP_W    = 8;
   localparam int MARKER_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Default channel count
   localparam int DEF_NUM_CHANNELS = 7;

   // Saturation limit of a channel count
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   // Register reset values
   localparam logic [GAP_W-1:0]    GAP_TICKS_RST    = 8'd100;
   localparam logic [COUNT_W-1:0]  MIN_COUNT_RST    = 7'd25;
   localparam logic [MARKER_W-1:0] START_MARKER_RST = 8'h01;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_TICKS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_COUNT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_MARKER = 2'd2;

   typedef logic [COUNT_W-1:0] count_type;

endpackage

@@ rtl/rc_multichannel_pulse_decoder.sv @@
// Top level of the multichannel pulse decoder: tick counting and report output.
//
// Usage:
//   req_ channel takes one sample tick of the receiver channel levels per word
//   (bit i high means channel i+1 is high). The lowest-numbered high channel
//   gets its count raised, saturating at 127. A run of gap_ticks all-low ticks
//   ends the frame; a frame whose counts all reach min_count is valid. The first
//   valid frame after reset is dropped, each later one is reported on the rsp_
//   channel as NUM_CHANNELS+1 words: start_marker, then each count doubled,
//   with rsp_last_byte high on the final word.
//   Throughput: one tick per cycle unless stalled. The report starts in the
//   cycle after the frame-ending tick and drains one word per cycle unless
//   stalled, from a count snapshot; the next frame is counted while it drains.
//   req_stall rises only when a tick would end a reportable frame while the
//   previous report is still draining; it is held until the report is gone.
//   When the receiver stalls, the current word is held unchanged.
//   csr_ port writes gap_ticks, min_count and start_marker at any write enable;
//   write them only while the block is idle.
//   Reset (synchronous): registers return to 100, 25, 0x01, counts clear, the
//   block collects, the first valid frame will be dropped, no report pending.
module rc_multichannel_pulse_decoder #(
   parameter int NUM_CHANNELS = rcpd_pkg::DEF_NUM_CHANNELS
) (
   input  logic                            clock,
   input  logic                            reset,
   // sample tick input
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [NUM_CHANNELS-1:0]         req_channel_levels,
   // report output
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rcpd_pkg::MARKER_W-1:0]   rsp_out_byte,
   output logic                            rsp_last_byte,
   // register writes
   input  logic                            csr_we,
   input  logic [rcpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rcpd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int REM_W = $clog2(NUM_CHANNELS + 1);
   localparam logic [REM_W-1:0] REM_FULL = REM_W'(NUM_CHANNELS);
   localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);

   // Configuration registers
   logic [rcpd_pkg::GAP_W-1:0]    gap_ticks_ff;
   logic [rcpd_pkg::COUNT_W-1:0]  min_count_ff;
   logic [rcpd_pkg::MARKER_W-1:0] start_marker_ff;

   // Frame state
   logic                          waiting_ff, waiting_in;
   logic [rcpd_pkg::GAP_W-1:0]    low_run_ff, low_run_in;
   logic                          first_pending_ff, first_pending_in;
   rcpd_pkg::count_type           count_ff [NUM_CHANNELS];
   rcpd_pkg::count_type           count_in [NUM_CHANNELS];

   // Report output stage
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rcpd_pkg::MARKER_W-1:0] out_byte_ff, out_byte_in;
   logic                          last_ff, last_in;
   logic [REM_W-1:0]              remain_ff, remain_in;
   rcpd_pkg::count_type           snap_ff [NUM_CHANNELS];
   rcpd_pkg::count_type           snap_in [NUM_CHANNELS];

   logic                          req_take;
   logic                          rsp_take;
   logic                          any_high;
   logic [NUM_CHANNELS-1:0]       pick;
   logic [rcpd_pkg::GAP_W-1:0]    low_run_plus;
   logic                          frame_end;
   logic                          frame_ok;
   logic                          would_report;
   logic                          fire;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ticks_ff    <= rcpd_pkg::GAP_TICKS_RST;
         min_count_ff    <= rcpd_pkg::MIN_COUNT_RST;
         start_marker_ff <= rcpd_pkg::START_MARKER_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            rcpd_pkg::CSR_GAP_TICKS:    gap_ticks_ff    <= csr_wdata;
            rcpd_pkg::CSR_MIN_COUNT:    min_count_ff    <= csr_wdata[rcpd_pkg::COUNT_W-1:0];
            rcpd_pkg::CSR_START_MARKER: start_marker_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pick the lowest-numbered high channel
   assign any_high = |req_channel_levels;
   assign pick     = req_channel_levels & (~req_channel_levels + NUM_CHANNELS'(1));

   // Check every count against the minimum
   always_comb begin
      frame_ok = 1'b1;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (count_ff[i] < min_count_ff) begin
            frame_ok = 1'b0;
         end
      end
   end

   // Detect a tick that ends a reportable frame
   assign low_run_plus = low_run_ff + rcpd_pkg::GAP_W'(1);
   assign frame_end    = !waiting_ff && !any_high && (low_run_plus == gap_ticks_ff);
   assign would_report = frame_end && frame_ok && !first_pending_ff;

   // Hold input while a report drains and this tick would start another
   assign req_stall = rsp_valid_ff && would_report;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign fire      = req_take && would_report;

   // Advance frame state for an accepted tick
   always_comb begin
      waiting_in       = waiting_ff;
      low_run_in       = low_run_ff;
      first_pending_in = first_pending_ff;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         count_in[i] = count_ff[i];
      end
      if (req_take) begin
         if (waiting_ff) begin
            if (any_high) begin
               waiting_in = 1'b0;
               low_run_in = '0;
               for (int i = 0; i < NUM_CHANNELS; i++) begin
                  count_in[i] = pick[i] ? rcpd_pkg::COUNT_W'(1) : '0;
               end
            end
         end else if (any_high) begin
            low_run_in = '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               if (pick[i] && (count_ff[i] != rcpd_pkg::COUNT_MAX)) begin
                  count_in[i] = count_ff[i] + rcpd_pkg::COUNT_W'(1);
               end
            end
         end else begin
            low_run_in = low_run_plus;
            if (frame_end) begin
               waiting_in = 1'b1;
               if (frame_ok) begin
                  first_pending_in = 1'b0;
               end
            end
         end
      end
   end

   // Load a report or shift out the next word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_byte_in  = out_byte_ff;
      last_in      = last_ff;
      remain_in    = remain_ff;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         snap_in[i] = snap_ff[i];
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
         out_byte_in  = start_marker_ff;
         last_in      = 1'b0;
         remain_in    = REM_FULL;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            snap_in[i] = count_ff[i];
         end
      end else if (rsp_take) begin
         if (remain_ff == '0) begin
            rsp_valid_in = 1'b0;
         end else begin
            out_byte_in = {snap_ff[0], 1'b0};
            last_in     = (remain_ff == REM_ONE);
            remain_in   = remain_ff - REM_ONE;
            for (int i = 0; i < NUM_CHANNELS - 1; i++) begin
               snap_in[i] = snap_ff[i+1];
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff       <= 1'b0;
         low_run_ff       <= '0;
         first_pending_ff <= 1'b1;
         rsp_valid_ff     <= 1'b0;
         remain_ff        <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         waiting_ff       <= waiting_in;
         low_run_ff       <= low_run_in;
         first_pending_ff <= first_pending_in;
         rsp_valid_ff     <= rsp_valid_in;
         remain_ff        <= remain_in;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      last_ff     <= last_in;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         snap_ff[i] <= snap_in[i];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_last_byte = last_ff;

   // A report starts with the marker in the cycle after the frame-ending tick
   a_fire_loads_marker: assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_valid && (rsp_out_byte == $past(start_marker_ff)) && !rsp_last_byte))
      else $error("report did not start with the start marker");

   // A new report never overruns one still draining
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && req_take) |-> !would_report)
      else $error("report started while previous report pending");

   // The output goes idle right after the last word is taken
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_last_byte) |=> !rsp_valid)
      else $error("output still valid after last word");

   // The last flag comes only when the word counter has run out
   a_last_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_byte) |-> (remain_ff == '0))
      else $error("last flag before the end of the report");

   // A high tick while waiting restarts collection with a clear gap run
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (req_take && waiting_ff && any_high) |=> (!waiting_ff && (low_run_ff == '0)))
      else $error("waiting phase did not restart collection");

endmodule

@@ dv/rc_pulse_report_checker.sv @@
// Checker for the pulse decoder: tracks decoder state from accepted words and checks reports.
module rc_pulse_report_checker #(
   parameter int NUM_CH = rcpd_pkg::DEF_NUM_CHANNELS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [NUM_CH-1:0]               req_channel_levels,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [rcpd_pkg::MARKER_W-1:0]   rsp_out_byte,
   input  logic                            rsp_last_byte,
   input  logic                            csr_we,
   input  logic [rcpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rcpd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              pending,
   output int                              mismatches
);

   typedef struct packed {
      logic [rcpd_pkg::MARKER_W-1:0] out_byte;
      logic                          last_byte;
   } report_word_type;

   // Shadow registers
   logic [rcpd_pkg::GAP_W-1:0]    gap_cfg;
   rcpd_pkg::count_type           min_cfg;
   logic [rcpd_pkg::MARKER_W-1:0] marker_cfg;

   // Shadow decoder state
   logic                          awaiting_activity;
   logic [rcpd_pkg::GAP_W-1:0]    quiet_run;
   rcpd_pkg::count_type           tally [NUM_CH];
   logic                          drop_next_frame;

   report_word_type     expected_words [$];
   int                  errs = 0;

   // Raise the count of the lowest-numbered high channel; report whether any was high.
   function automatic bit bump_lowest(input logic [NUM_CH-1:0] lv);
      for (int i = 0; i < NUM_CH; i++) begin
         if (lv[i]) begin
            if (tally[i] != rcpd_pkg::COUNT_MAX)
               tally[i] = tally[i] + 1'b1;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Advance the shadow state by one sample tick and queue any report it causes.
   task automatic decode_tick(input logic [NUM_CH-1:0] lv);
      bit frame_ok;
      if (awaiting_activity) begin
         if (lv != '0) begin
            awaiting_activity = 1'b0;
            quiet_run = '0;
            foreach (tally[i]) tally[i] = '0;
            void'(bump_lowest(lv));
         end
         return;
      end
      if (bump_lowest(lv)) begin
         quiet_run = '0;
         return;
      end
      // a gap setting of zero wraps the run counter, so the frame ends after 256 lows
      quiet_run = quiet_run + 1'b1;
      if (quiet_run != gap_cfg)
         return;
      awaiting_activity = 1'b1;
      frame_ok = 1'b1;
      foreach (tally[i])
         if (tally[i] < min_cfg)
            frame_ok = 1'b0;
      if (!frame_ok)
         return;
      if (drop_next_frame) begin
         drop_next_frame = 1'b0;
         return;
      end
      expected_words.push_back('{marker_cfg, 1'b0});
      foreach (tally[i])
         expected_words.push_back('{{tally[i], 1'b0}, (i == NUM_CH - 1)});
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gap_cfg           = rcpd_pkg::GAP_TICKS_RST;
         min_cfg           = rcpd_pkg::MIN_COUNT_RST;
         marker_cfg        = rcpd_pkg::START_MARKER_RST;
         awaiting_activity = 1'b0;
         quiet_run         = '0;
         foreach (tally[i]) tally[i] = '0;
         drop_next_frame   = 1'b1;
         expected_words.delete();
      end else begin
         // register writes; unmapped indexes fall through
         if (csr_we) begin
            case (csr_index)
               rcpd_pkg::CSR_GAP_TICKS:    gap_cfg = csr_wdata;
               rcpd_pkg::CSR_MIN_COUNT:    min_cfg = csr_wdata[rcpd_pkg::COUNT_W-1:0];
               rcpd_pkg::CSR_START_MARKER: marker_cfg = csr_wdata;
               default: ;
            endcase
         end
         // compare each report word against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("unexpected report word: out_byte %0h last_byte %0b",
                      rsp_out_byte, rsp_last_byte);
               errs++;
            end else begin
               report_word_type want;
               want = expected_words.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_out_byte);
                  errs++;
               end
               if (rsp_last_byte !== want.last_byte) begin
                  $error("last_byte: expected %0b, got %0b", want.last_byte, rsp_last_byte);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall)
            decode_tick(req_channel_levels);
      end
      pending    <= expected_words.size();
      mismatches <= errs;
   end

endmodule

@@ dv/tb_rc_multichannel_pulse_decoder.sv @@
// Testbench top for the pulse decoder: clock, reset, tick stimulus, receiver idling and verdict.
module tb_rc_multichannel_pulse_decoder;

   localparam int NUM_CH        = rcpd_pkg::DEF_NUM_CHANNELS;
   localparam int MAX_IDLE      = 17;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 4000;
   localparam int RANDOM_TICKS  = 60;
   localparam int SAT_TICKS     = 130;
   localparam int ZERO_GAP_LOWS = 256;

   localparam logic [rcpd_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef logic [NUM_CH-1:0] level_type;

   // Mixed levels under the reset settings; too few lows to end a frame
   localparam level_type WARMUP [11] = '{7'h00, 7'h7F, 7'h01, 7'h02, 7'h04, 7'h08,
                                         7'h10, 7'h20, 7'h40, 7'h55, 7'h2A};
   // Dropped first frame, ignored low, invalid frame, then a reported frame
   localparam level_type OPENING [17] = '{7'h00, 7'h00, 7'h00, 7'h7E, 7'h00, 7'h00,
                                          7'h01, 7'h02, 7'h04, 7'h08, 7'h10, 7'h20,
                                          7'h40, 7'h00, 7'h7F, 7'h00, 7'h00};

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   level_type                       req_channel_levels = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [rcpd_pkg::MARKER_W-1:0]   rsp_out_byte;
   logic                            rsp_last_byte;
   logic                            csr_we = 1'b0;
   logic [rcpd_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [rcpd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int          pending;
   int          mismatches;
   int unsigned tick_count = 0;
   bit          tx_calm = 1'b0;
   bit          rx_calm = 1'b0;
   int unsigned hold_asks = 0;

   rc_multichannel_pulse_decoder #(.NUM_CHANNELS(NUM_CH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_channel_levels(req_channel_levels),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte), .rsp_last_byte(rsp_last_byte),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   rc_pulse_report_checker #(.NUM_CH(NUM_CH)) report_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_channel_levels(req_channel_levels),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte), .rsp_last_byte(rsp_last_byte),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .pending(pending), .mismatches(mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Offer one tick word after a drawn pause; hold it until accepted.
   task automatic send_tick(input level_type lv);
      int unsigned pause;
      pause = tx_calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (pause > 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_channel_levels <= lv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tick_count++;
   endtask

   // Drop valid, wait for every queued report word, then let the block go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers and an unmapped index in one burst.
   task automatic program_regs(input logic [rcpd_pkg::CSR_DATA_W-1:0] gap,
                               input logic [rcpd_pkg::CSR_DATA_W-1:0] min_raw,
                               input logic [rcpd_pkg::CSR_DATA_W-1:0] marker);
      csr_we    <= 1'b1;
      csr_index <= rcpd_pkg::CSR_GAP_TICKS;
      csr_wdata <= gap;
      @(posedge clock);
      csr_index <= rcpd_pkg::CSR_MIN_COUNT;
      csr_wdata <= min_raw;
      @(posedge clock);
      csr_index <= rcpd_pkg::CSR_START_MARKER;
      csr_wdata <= marker;
      @(posedge clock);
      csr_index <= CSR_UNMAPPED;
      csr_wdata <= rcpd_pkg::CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Send one frame: shuffled channel ticks, short low runs, the ending gap, idle lows.
   task automatic send_frame(input int unsigned floor_cnt, input int unsigned spread,
                             input logic [rcpd_pkg::GAP_W-1:0] gap, input bit spoil);
      int unsigned left [NUM_CH];
      int unsigned total;
      int unsigned ch;
      int unsigned quiet;
      int unsigned lows;
      level_type   lv;
      quiet = (gap == '0) ? 256 : gap;
      foreach (left[i]) left[i] = floor_cnt + $urandom_range(0, spread);
      // short one channel so the frame misses the minimum
      if (spoil && floor_cnt > 0)
         left[$urandom_range(0, NUM_CH - 1)] = $urandom_range(0, floor_cnt - 1);
      total = 0;
      foreach (left[i]) total += left[i];
      while (total > 0) begin
         ch = $urandom_range(0, NUM_CH - 1);
         while (left[ch] == 0) ch = (ch + 1) % NUM_CH;
         left[ch]--;
         total--;
         lv = (level_type'($urandom) & (level_type'('1) << ch)) | (level_type'(1) << ch);
         send_tick(lv);
         // low run that stays short of the gap
         if (quiet > 1 && $urandom_range(0, 7) == 0) begin
            if (quiet <= 8 && $urandom_range(0, 1) == 1)
               lows = quiet - 1;
            else
               lows = $urandom_range(1, (quiet - 1 > 5) ? 5 : quiet - 1);
            repeat (lows) send_tick('0);
         end
      end
      repeat (quiet) send_tick('0);
      repeat ($urandom_range(0, 3)) send_tick('0);
   endtask

   // Receiver: draw a stall per word, or the long hold-off when one is requested.
   initial begin : receiver
      int unsigned hold;
      int unsigned holds_done;
      holds_done = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_asks != holds_done) begin
            holds_done = hold_asks;
            hold = LONG_HOLD;
         end else begin
            hold = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // End the run when nothing moves on either channel for too long.
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("rc_multichannel_pulse_decoder test failed");
      $finish;
   end

   initial begin : stimulus
      logic [rcpd_pkg::GAP_W-1:0] gap;
      int unsigned                floor_cnt;
      int unsigned                goal;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // warm up under the reset settings
      foreach (WARMUP[i]) send_tick(WARMUP[i]);
      settle();

      // opening frames: dropped, invalid, then reported
      program_regs(8'd2, 8'd1, 8'hFF);
      foreach (OPENING[i]) send_tick(OPENING[i]);
      settle();

      // random phases with small gaps and minimums
      goal = tick_count + RANDOM_TICKS;
      while (tick_count < goal) begin
         gap       = rcpd_pkg::GAP_W'($urandom_range(1, 6));
         floor_cnt = $urandom_range(0, 3);
         program_regs(gap, 8'(floor_cnt) | 8'($urandom_range(0, 1) << 7),
                      rcpd_pkg::CSR_DATA_W'($urandom));
         tx_calm = ($urandom_range(0, 3) == 0);
         rx_calm <= ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(3, 5))
            send_frame(floor_cnt, 3, gap, $urandom_range(0, 5) == 0);
         repeat ($urandom_range(0, 6))
            send_tick(($urandom_range(0, 2) == 0) ? '0 : level_type'($urandom));
         settle();
      end

      // hold the receiver off while frames keep ending, so the input stalls
      program_regs(8'd1, 8'd0, 8'hA5);
      tx_calm = 1'b1;
      rx_calm <= 1'b0;
      hold_asks <= hold_asks + 1;
      repeat (5) send_frame(0, 2, 8'd1, 1'b0);
      settle();

      // gap of zero, zero minimum with masked write, one channel saturating
      program_regs(8'd0, 8'h80, 8'h00);
      tx_calm = ($urandom_range(0, 1) == 1);
      repeat (SAT_TICKS) send_tick(level_type'($urandom) | level_type'(1));
      repeat (ZERO_GAP_LOWS) send_tick('0);
      settle();

      // top minimum with masked write; short frames come out invalid
      program_regs(8'd1, 8'hFF, 8'h00);
      tx_calm = 1'b0;
      repeat (2) send_frame(0, 2, 8'd1, 1'b0);
      settle();

      // tight frames with full idling on both sides
      program_regs(8'd1, 8'd1, 8'h5A);
      rx_calm <= 1'b0;
      repeat (4) send_frame(1, 2, 8'd1, $urandom_range(0, 2) == 0);
      settle();

      if (mismatches == 0)
         $display("rc_multichannel_pulse_decoder test passed");
      else
         $display("rc_multichannel_pulse_decoder test failed");
      $finish;
   end

endmodule
